/* rtl/core/dfr_pkg.sv */
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and codes for the sync word / length prefixed deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

  localparam logic [2:0] ST_DROP  = 3'd0;
  localparam logic [2:0] ST_HEAD  = 3'd1;
  localparam logic [2:0] ST_BODY  = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;

  localparam logic [1:0] CL_FRAME   = 2'd0;
  localparam logic [1:0] CL_TRIGGER = 2'd1;
  localparam logic [1:0] CL_CALIB   = 2'd2;
  localparam logic [1:0] CL_OTHER   = 2'd3;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUNT_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_CODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_CODE   = 3'd4;

  localparam logic [31:0] SYNC_WORD_RST    = 32'h5283a76b;
  localparam logic [31:0] FRAME_CODE_RST   = 32'd33;
  localparam logic [31:0] TRIGGER_CODE_RST = 32'd34;
  localparam logic [31:0] CALIB_CODE_RST   = 32'd36;

  typedef struct packed {
    logic [31:0] sync_word;
    logic        hunt_enable;
    logic [31:0] frame_code;
    logic [31:0] trigger_code;
    logic [31:0] calib_code;
  } dfr_cfg_t;

  // classified byte handed from the front to the back
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  pbyte;
    logic        type_vld;
    logic [31:0] mtype;
    logic [31:0] pidx;
    logic        last;
    logic        trig_en;
    logic [1:0]  trig_pos;
    logic        trig_clr;
  } dfr_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/dfr_in_if.sv */
// ----------------------------------------------------------------------------
// dfr_in_if
// Received byte stream channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/dfr_out_if.sv */
// ----------------------------------------------------------------------------
// dfr_out_if
// Per byte result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  payload_byte;
  logic [31:0] message_type;
  logic [1:0]  message_class;
  logic [31:0] payload_index;
  logic        last_byte;
  logic        trigger_valid;
  logic [31:0] trigger_value;

  modport source (output valid, output status, output payload_byte, output message_type,
                  output message_class, output payload_index, output last_byte,
                  output trigger_valid, output trigger_value, input ready);
  modport sink   (input valid, input status, input payload_byte, input message_type,
                  input message_class, input payload_index, input last_byte,
                  input trigger_valid, input trigger_value, output ready);
endinterface

`default_nettype wire

/* rtl/core/dfr_front.sv */
// ----------------------------------------------------------------------------
// dfr_front
// Accepts bytes, tracks sync / header / payload phase and classifies each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_front
  import dfr_pkg::*;
#(
  parameter int unsigned LEN_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire dfr_cfg_t cfg,
  input  wire logic     in_vld,
  input  wire logic [7:0] in_byte,
  output logic          in_rdy,
  input  wire logic     q_full,
  output logic          q_push,
  output dfr_cmd_t      q_cmd
);

  typedef enum logic [3:0] {
    PH_SYNC = 4'b0001,
    PH_HEAD = 4'b0010,
    PH_BODY = 4'b0100,
    PH_HALT = 4'b1000
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [31:0]            shift_r, shift_nxt;
  logic [3:0]             hcnt_r, hcnt_nxt;
  logic [31:0]            type_r, type_nxt;
  logic [31:0]            len_r, len_nxt;
  logic [LEN_WIDTH-1:0]   pc_r, pc_nxt;
  logic [LEN_WIDTH:0]     pc_inc;
  logic [31:0]            byte_ext;
  logic [4:0]             byte_sh;

  assign in_rdy   = !q_full;
  assign q_push   = in_vld && !q_full;
  assign pc_inc   = {1'b0, pc_r} + 1'b1;
  assign byte_ext = {24'd0, in_byte};
  assign byte_sh  = {hcnt_r[1:0], 3'b000};

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    hcnt_nxt  = hcnt_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    pc_nxt    = pc_r;
    q_cmd     = '0;
    case (phase_r)
      PH_SYNC: begin
        shift_nxt = {in_byte, shift_r[31:8]};
        if (hcnt_r < 4'd4) begin
          hcnt_nxt = hcnt_r + 4'd1;
        end
        if (hcnt_nxt >= 4'd4 && shift_nxt == cfg.sync_word) begin
          q_cmd.status = ST_HEAD;
          phase_nxt    = PH_HEAD;
          hcnt_nxt     = 4'd0;
          type_nxt     = '0;
          len_nxt      = '0;
        end else if (cfg.hunt_enable) begin
          q_cmd.status = ST_DROP;
        end else if (hcnt_nxt >= 4'd4) begin
          q_cmd.status = ST_ERR;
          phase_nxt    = PH_HALT;
        end else begin
          q_cmd.status = ST_HEAD;
        end
      end
      PH_HEAD: begin
        if (hcnt_r < 4'd4) begin
          type_nxt = type_r | (byte_ext << byte_sh);
        end else begin
          len_nxt = len_r | (byte_ext << byte_sh);
        end
        hcnt_nxt = hcnt_r + 4'd1;
        if (hcnt_nxt >= 4'd4) begin
          q_cmd.type_vld = 1'b1;
          q_cmd.mtype    = type_nxt;
        end
        q_cmd.status = ST_HEAD;
        if (hcnt_nxt == 4'd8) begin
          if ((len_nxt >> LEN_WIDTH) != 32'd0) begin
            q_cmd.status   = ST_ERR;
            q_cmd.type_vld = 1'b0;
            q_cmd.mtype    = '0;
            phase_nxt      = PH_HALT;
          end else if (len_nxt == 32'd0) begin
            q_cmd.status = ST_EMPTY;
            q_cmd.last   = 1'b1;
            phase_nxt    = PH_SYNC;
            shift_nxt    = '0;
            hcnt_nxt     = 4'd0;
          end else begin
            q_cmd.trig_clr = 1'b1;
            phase_nxt      = PH_BODY;
            pc_nxt         = '0;
          end
        end
      end
      PH_BODY: begin
        q_cmd.status   = ST_BODY;
        q_cmd.pbyte    = in_byte;
        q_cmd.type_vld = 1'b1;
        q_cmd.mtype    = type_r;
        q_cmd.pidx     = 32'(pc_r);
        q_cmd.trig_en  = (len_r >= 32'd4) && (pc_r < LEN_WIDTH'(4));
        q_cmd.trig_pos = pc_r[1:0];
        if (pc_inc >= {1'b0, len_r[LEN_WIDTH-1:0]}) begin
          q_cmd.last = 1'b1;
          phase_nxt  = PH_SYNC;
          shift_nxt  = '0;
          hcnt_nxt   = 4'd0;
        end else begin
          pc_nxt = pc_inc[LEN_WIDTH-1:0];
        end
      end
      PH_HALT: begin
        q_cmd.status = ST_ERR;
      end
      default: begin
        q_cmd.status = ST_ERR;
        phase_nxt    = PH_HALT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC;
      shift_r <= '0;
      hcnt_r  <= '0;
      type_r  <= '0;
      len_r   <= '0;
      pc_r    <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      hcnt_r  <= hcnt_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dfr_queue.sv */
// ----------------------------------------------------------------------------
// dfr_queue
// Two entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_queue
  import dfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire dfr_cmd_t push_cmd,
  output logic          full,
  input  wire logic     pop,
  output logic          head_vld,
  output dfr_cmd_t      head_cmd
);

  dfr_cmd_t   ent_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign head_vld = (cnt_r != 2'd0);
  assign head_cmd = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dfr_back.sv */
// ----------------------------------------------------------------------------
// dfr_back
// Resolves message class, assembles trigger counts and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_back
  import dfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire dfr_cfg_t cfg,
  input  wire logic     head_vld,
  input  wire dfr_cmd_t head_cmd,
  output logic          pop,
  dfr_out_if.source     out_chan
);

  function automatic logic [1:0] class_of(input logic [31:0] t, input dfr_cfg_t c);
    logic [1:0] cls;
    if (t == c.frame_code) begin
      cls = CL_FRAME;
    end else if (t == c.trigger_code) begin
      cls = CL_TRIGGER;
    end else if (t == c.calib_code) begin
      cls = CL_CALIB;
    end else begin
      cls = CL_OTHER;
    end
    return cls;
  endfunction

  logic        out_vld_r;
  logic [2:0]  status_r;
  logic [7:0]  pbyte_r;
  logic [31:0] mtype_r;
  logic [1:0]  class_r;
  logic [31:0] pidx_r;
  logic        last_r;
  logic        tvld_r;
  logic [31:0] tval_r;
  logic [31:0] accum_r, accum_nxt;
  logic [1:0]  cls;
  logic        tvld;

  assign pop = head_vld && (!out_vld_r || out_chan.ready);
  assign cls = head_cmd.type_vld ? class_of(head_cmd.mtype, cfg) : CL_FRAME;

  always_comb begin
    accum_nxt = accum_r;
    tvld      = 1'b0;
    if (head_cmd.trig_clr) begin
      accum_nxt = '0;
    end else if (head_cmd.trig_en && cls == CL_TRIGGER) begin
      accum_nxt = accum_r | ({24'd0, head_cmd.pbyte} << {head_cmd.trig_pos, 3'b000});
      tvld      = (head_cmd.trig_pos == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      accum_r   <= '0;
    end else begin
      if (pop) begin
        out_vld_r <= 1'b1;
        accum_r   <= accum_nxt;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= head_cmd.status;
      pbyte_r  <= head_cmd.pbyte;
      mtype_r  <= head_cmd.mtype;
      class_r  <= cls;
      pidx_r   <= head_cmd.pidx;
      last_r   <= head_cmd.last;
      tvld_r   <= tvld;
      tval_r   <= tvld ? accum_nxt : 32'd0;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.status        = status_r;
  assign out_chan.payload_byte  = pbyte_r;
  assign out_chan.message_type  = mtype_r;
  assign out_chan.message_class = class_r;
  assign out_chan.payload_index = pidx_r;
  assign out_chan.last_byte     = last_r;
  assign out_chan.trigger_valid = tvld_r;
  assign out_chan.trigger_value = tval_r;

endmodule

`default_nettype wire

/* rtl/core/sync_length_message_deframer.sv */
// ----------------------------------------------------------------------------
// sync_length_message_deframer
// Finds a sync word, reads a little-endian type and length header and passes
// payload bytes on with index, class, last flag and trigger count.
// ----------------------------------------------------------------------------
// each byte's result is registered first in a queue entry, then in the output register
// throughput: one byte per cycle while the queue is not full, set by the phase update in the front
// a full two entry queue stalls the input while the output is held
// reset: synchronous active low; config returns to defaults, parser to sync hunt
`default_nettype none

module sync_length_message_deframer
  import dfr_pkg::*;
#(
  parameter int unsigned LEN_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_wdata,
  dfr_in_if.sink                    in_chan,
  dfr_out_if.source                 out_chan
);

  dfr_cfg_t cfg_r;
  dfr_cmd_t push_cmd, head_cmd;
  logic     q_full, q_push, q_pop, head_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_word    <= SYNC_WORD_RST;
      cfg_r.hunt_enable  <= 1'b0;
      cfg_r.frame_code   <= FRAME_CODE_RST;
      cfg_r.trigger_code <= TRIGGER_CODE_RST;
      cfg_r.calib_code   <= CALIB_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_WORD:    cfg_r.sync_word    <= cfg_wdata;
        REG_HUNT_ENABLE:  cfg_r.hunt_enable  <= cfg_wdata[0];
        REG_FRAME_CODE:   cfg_r.frame_code   <= cfg_wdata;
        REG_TRIGGER_CODE: cfg_r.trigger_code <= cfg_wdata;
        REG_CALIB_CODE:   cfg_r.calib_code   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  dfr_front #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_vld  (in_chan.valid),
    .in_byte (in_chan.rx_byte),
    .in_rdy  (in_chan.ready),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (push_cmd)
  );

  dfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_vld (head_vld),
    .head_cmd (head_cmd)
  );

  dfr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head_vld (head_vld),
    .head_cmd (head_cmd),
    .pop      (q_pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
